/* design/ldsp_pkg.sv */
// ----------------------------------------------------------------------------
// ldsp_pkg: shared types and constants for the LED slew/PWM dimmer
// Fixed field widths, register indexes, reset values, multiply/divide opcodes.
// ----------------------------------------------------------------------------
package ldsp_pkg;

  // level is unsigned Q0.16 with one extra bit so that 1.0 is representable
  localparam int LVL_W       = 17;
  localparam int FRAC_W      = 16;
  localparam int PCT_W       = 7;
  localparam int MS_W        = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [LVL_W-1:0] FULL_LEVEL = 17'd65536;
  localparam logic [LVL_W-1:0] SNAP_LSB   = 17'd66;
  localparam logic [LVL_W-1:0] OFF_LSB    = 17'd66;

  localparam int MAX_STEP_MS_DEF = 100;

  // target = (pct * 2^16 + 50) / 100
  localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
  localparam int               TGT_DIVISOR = 100;
  localparam int               TGT_ROUND   = 50;
  localparam int               TGT_NUM_W   = 23;

  // same target by reciprocal: (pct * ceil(2^32/100) + 2^15) >> 16,
  // exact for pct 0..100
  localparam int               TGT_RECIP   = 42949673;
  localparam int               TGT_SHIFT   = 16;

  // smoothstep: (x^2 * (3*2^16 - 2x) + 2^15) >> 16, then * period >> 32
  localparam int SS_K       = 196608;
  localparam int SS_K_W     = 18;
  localparam int SQ_W       = 33;
  localparam int SS_SHIFT   = 16;
  localparam int CMP_SHIFT  = 32;

  // multiplier operand width of the shared unit
  localparam int MDU_B_W    = 18;

  // register reset values
  localparam logic              EN_RST      = 1'b0;
  localparam logic [PCT_W-1:0]  PCT_RST     = 7'd100;
  localparam logic [MS_W-1:0]   ATTACK_RST  = 16'd1400;
  localparam logic [MS_W-1:0]   RELEASE_RST = 16'd2200;
  localparam logic [MS_W-1:0]   PERIOD_RST  = 16'd65535;
  localparam logic              ALOW_RST    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED    = 3'd0,
    REG_BRIGHTNESS = 3'd1,
    REG_ATTACK     = 3'd2,
    REG_RELEASE    = 3'd3,
    REG_PERIOD     = 3'd4,
    REG_ACTIVE_LOW = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    ACT_TICK      = 1'b0,
    ACT_FORCE_OFF = 1'b1
  } action_t;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

endpackage

/* design/ldsp_mdu.sv */
// ----------------------------------------------------------------------------
// ldsp_mdu: iterative multiply/divide unit
// Radix-2 shift-add multiply and restoring divide on one shared adder.
// ----------------------------------------------------------------------------
module ldsp_mdu
  import ldsp_pkg::*;
#(
  parameter int A_W = 33,
  parameter int B_W = 18,
  parameter int Q_W = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mdu_req_t           req,
  input  logic [A_W-1:0]     opnd_a,
  input  logic [B_W-1:0]     opnd_b,
  output logic               done,
  output logic [A_W+B_W-1:0] result
);

  localparam int N_MAX = (B_W > Q_W) ? B_W : Q_W;
  localparam int CNT_W = $clog2(N_MAX + 1);

  typedef enum logic {M_IDLE, M_RUN} mstate_t;

  mstate_t          st_r;
  mdu_op_t          op_r;
  logic [A_W:0]     hi_r;
  logic [B_W-1:0]   lo_r;
  logic [A_W-1:0]   a_r;
  logic [B_W-1:0]   b_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [B_W:0]     trial;
  logic [A_W+1:0]   add_a;
  logic [A_W+1:0]   add_b;
  logic [A_W+1:0]   sum;
  logic             ge;

  // div: lo_r is the partial remainder, hi_r shifts the dividend out MSB first
  assign trial = {lo_r, hi_r[Q_W-1]};

  always_comb begin
    if (op_r == MDU_MUL) begin
      add_a = {1'b0, hi_r};
      add_b = lo_r[0] ? {2'b00, a_r} : '0;
      sum   = add_a + add_b;
    end else begin
      add_a = {(A_W+1-B_W)'(0), trial};
      add_b = {1'b0, ~{(A_W+1-B_W)'(0), b_r}};
      sum   = add_a + add_b + (A_W+2)'(1);
    end
  end

  assign ge = sum[A_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= M_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        M_IDLE: begin
          if (req.start) begin
            op_r <= req.op;
            a_r  <= opnd_a;
            b_r  <= opnd_b;
            st_r <= M_RUN;
            if (req.op == MDU_MUL) begin
              hi_r  <= '0;
              lo_r  <= opnd_b;
              cnt_r <= CNT_W'(B_W);
            end else begin
              hi_r  <= {1'b0, opnd_a};
              lo_r  <= '0;
              cnt_r <= CNT_W'(Q_W);
            end
          end
        end
        M_RUN: begin
          if (op_r == MDU_MUL) begin
            hi_r <= {1'b0, sum[A_W:1]};
            lo_r <= {sum[0], lo_r[B_W-1:1]};
          end else begin
            hi_r <= {hi_r[A_W-1:0], ge};
            lo_r <= ge ? sum[B_W-1:0] : trial[B_W-1:0];
          end
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            done_r <= 1'b1;
            st_r   <= M_IDLE;
          end
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = (op_r == MDU_MUL) ? {hi_r[A_W-1:0], lo_r}
                                    : (A_W+B_W)'(hi_r[Q_W-1:0]);

endmodule

/* design/led_dimmer_slew_pwm_top.sv */
// ----------------------------------------------------------------------------
// led_dimmer_slew_pwm_top: exponential slew LED dimmer with smoothstep PWM
// Moves a Q0.16 level toward the brightness target and emits a PWM compare.
// ----------------------------------------------------------------------------
// Tick with nonzero time constant: target, step multiply, step divide, then the
//   smoothstep compare; zero time constant skips the step; force off skips both.
// One transaction in flight; the next is taken the cycle after the result is
//   registered. Each step waits on the bit-serial multiply/divide unit.
// Reset (synchronous, rst_n low): level 0, registers to their defaults, idle.
// ----------------------------------------------------------------------------
module led_dimmer_slew_pwm_top
  import ldsp_pkg::*;
#(
  parameter int MAX_STEP_MS = MAX_STEP_MS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [MS_W-1:0]       in_elapsed_ms,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MS_W-1:0]       out_compare_value,
  output logic                  out_is_off,
  output logic [LVL_W-1:0]      out_level_out,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // dt width, divider quotient width, multiplicand width, product width
  localparam int DT_W  = $clog2(MAX_STEP_MS + 1);
  localparam int NUM_W = LVL_W + DT_W + 1;
  localparam int Q_W   = (NUM_W > TGT_NUM_W) ? NUM_W : TGT_NUM_W;
  localparam int A_W   = (Q_W > SQ_W) ? Q_W : SQ_W;
  localparam int B_W   = MDU_B_W;
  localparam int P_W   = A_W + B_W;

  // Sequencer. Each *_W state waits on the shared unit; the state before it
  // issues the request.
  typedef enum logic [3:0] {
    S_IDLE, S_TGT, S_TGT_W, S_SETUP, S_MUL, S_MUL_W, S_DIV, S_DIV_W,
    S_APPLY, S_SQ, S_SQ_W, S_CUBE, S_CUBE_W, S_PER, S_PER_W, S_OUT
  } state_t;

  state_t            state_r;

  // configuration registers
  logic              en_r;
  logic [PCT_W-1:0]  pct_r;
  logic [MS_W-1:0]   attack_r;
  logic [MS_W-1:0]   release_r;
  logic [MS_W-1:0]   period_r;
  logic              alow_r;

  // working state
  logic [LVL_W-1:0]  level_r;
  logic [LVL_W-1:0]  target_r;
  logic [LVL_W-1:0]  mag_r;
  logic [LVL_W-1:0]  den_r;
  logic [DT_W-1:0]   dt_r;
  logic              rising_r;
  logic [P_W-1:0]    acc_r;

  // result register
  logic              out_valid_r;
  logic [MS_W-1:0]   cmp_r;
  logic              off_r;
  logic [LVL_W-1:0]  lvl_out_r;

  // shared unit hookup
  mdu_req_t          mdu_req;
  logic [A_W-1:0]    mdu_a;
  logic [B_W-1:0]    mdu_b;
  logic              mdu_done;
  logic [P_W-1:0]    mdu_result;

  ldsp_mdu #(
    .A_W (A_W),
    .B_W (B_W),
    .Q_W (Q_W)
  ) u_mdu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mdu_req),
    .opnd_a (mdu_a),
    .opnd_b (mdu_b),
    .done   (mdu_done),
    .result (mdu_result)
  );

  logic              in_acc;
  logic              out_free;
  logic [DT_W-1:0]   dt_sat;
  logic [PCT_W-1:0]  pct_wr;

  logic [P_W-1:0]    tgt_rnd;

  logic              rising;
  logic [MS_W-1:0]   tau;
  logic [LVL_W-1:0]  mag;
  logic [LVL_W-1:0]  den;

  logic [Q_W-1:0]    step_num;
  logic [LVL_W-1:0]  step;
  logic [LVL_W-1:0]  moved;
  logic [LVL_W-1:0]  snap_gap;
  logic [LVL_W-1:0]  lvl_new;

  logic [SS_K_W-1:0] ss_mul;
  logic [P_W-1:0]    ss_rnd;
  logic [P_W-1:0]    cmp_rnd;
  logic [LVL_W-1:0]  cmp_raw;
  logic [MS_W-1:0]   cmp_sat;
  logic [MS_W-1:0]   cmp_fin;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // elapsed time is clamped to the longest step
  assign dt_sat = (in_elapsed_ms > MS_W'(MAX_STEP_MS)) ? DT_W'(MAX_STEP_MS)
                                                       : in_elapsed_ms[DT_W-1:0];
  assign pct_wr = (cfg_data[PCT_W-1:0] > PCT_MAX) ? PCT_MAX : cfg_data[PCT_W-1:0];

  // target = round(pct * 2^16 / 100) by reciprocal multiply, rounded shift
  assign tgt_rnd = mdu_result + (P_W'(1) << (TGT_SHIFT - 1));

  // direction and time constant; rising includes target == level
  assign rising = (target_r >= level_r);
  assign tau    = rising ? attack_r : release_r;
  assign mag    = rising ? (target_r - level_r) : (level_r - target_r);
  assign den    = LVL_W'(tau) + LVL_W'(dt_r);

  // rounded numerator of the step division
  assign step_num = acc_r[Q_W-1:0] + Q_W'(den_r >> 1);

  // apply the step, then snap onto the target when close enough
  assign step     = (acc_r[Q_W-1:0] > Q_W'(mag_r)) ? mag_r : acc_r[LVL_W-1:0];
  assign moved    = rising_r ? (level_r + step) : (level_r - step);
  assign snap_gap = rising_r ? (target_r - moved) : (moved - target_r);
  always_comb begin
    lvl_new = (snap_gap < SNAP_LSB) ? target_r : moved;
    if (lvl_new > FULL_LEVEL) begin
      lvl_new = FULL_LEVEL;
    end
  end

  // smoothstep pieces
  assign ss_mul  = SS_K_W'(SS_K) - {level_r, 1'b0};
  assign ss_rnd  = acc_r + (P_W'(1) << (SS_SHIFT - 1));
  assign cmp_rnd = acc_r + (P_W'(1) << (CMP_SHIFT - 1));
  assign cmp_raw = cmp_rnd[CMP_SHIFT +: LVL_W];
  assign cmp_sat = (cmp_raw > LVL_W'(period_r)) ? period_r : cmp_raw[MS_W-1:0];
  assign cmp_fin = alow_r ? (period_r - cmp_sat) : cmp_sat;

  // request mux for the shared unit
  always_comb begin
    mdu_req.start = 1'b0;
    mdu_req.op    = MDU_MUL;
    mdu_a         = '0;
    mdu_b         = '0;
    unique case (state_r)
      S_TGT: begin
        mdu_req.start = 1'b1;
        mdu_a         = A_W'(TGT_RECIP);
        mdu_b         = B_W'(pct_r);
      end
      S_MUL: begin
        mdu_req.start = 1'b1;
        mdu_a         = A_W'(mag_r);
        mdu_b         = B_W'(dt_r);
      end
      S_DIV: begin
        mdu_req.start = 1'b1;
        mdu_req.op    = MDU_DIV;
        mdu_a         = A_W'(step_num);
        mdu_b         = B_W'(den_r);
      end
      S_SQ: begin
        mdu_req.start = 1'b1;
        mdu_a         = A_W'(level_r);
        mdu_b         = B_W'(level_r);
      end
      S_CUBE: begin
        mdu_req.start = 1'b1;
        mdu_a         = acc_r[A_W-1:0];
        mdu_b         = B_W'(ss_mul);
      end
      S_PER: begin
        mdu_req.start = 1'b1;
        mdu_a         = ss_rnd[SS_SHIFT +: A_W];
        mdu_b         = B_W'(period_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= EN_RST;
      pct_r       <= PCT_RST;
      attack_r    <= ATTACK_RST;
      release_r   <= RELEASE_RST;
      period_r    <= PERIOD_RST;
      alow_r      <= ALOW_RST;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // register writes; unknown indexes fall through
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ENABLED:    en_r      <= cfg_data[0];
          REG_BRIGHTNESS: pct_r     <= pct_wr;
          REG_ATTACK:     attack_r  <= cfg_data;
          REG_RELEASE:    release_r <= cfg_data;
          REG_PERIOD:     period_r  <= cfg_data;
          REG_ACTIVE_LOW: alow_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            dt_r <= dt_sat;
            if (action_t'(in_action) == ACT_FORCE_OFF) begin
              // level 0 through the normal compare path gives the off value
              en_r    <= 1'b0;
              level_r <= '0;
              state_r <= S_SQ;
            end else begin
              state_r <= S_TGT;
            end
          end
        end
        S_TGT:   state_r <= S_TGT_W;
        S_TGT_W: begin
          if (mdu_done) begin
            target_r <= en_r ? tgt_rnd[TGT_SHIFT +: LVL_W] : '0;
            state_r  <= S_SETUP;
          end
        end
        S_SETUP: begin
          rising_r <= rising;
          mag_r    <= mag;
          den_r    <= den;
          if (tau == '0) begin
            level_r <= target_r;
            state_r <= S_SQ;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL:   state_r <= S_MUL_W;
        S_MUL_W: begin
          if (mdu_done) begin
            acc_r   <= mdu_result;
            state_r <= S_DIV;
          end
        end
        S_DIV:   state_r <= S_DIV_W;
        S_DIV_W: begin
          if (mdu_done) begin
            acc_r   <= mdu_result;
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          level_r <= lvl_new;
          state_r <= S_SQ;
        end
        S_SQ:    state_r <= S_SQ_W;
        S_SQ_W: begin
          if (mdu_done) begin
            acc_r   <= mdu_result;
            state_r <= S_CUBE;
          end
        end
        S_CUBE:  state_r <= S_CUBE_W;
        S_CUBE_W: begin
          if (mdu_done) begin
            acc_r   <= mdu_result;
            state_r <= S_PER;
          end
        end
        S_PER:   state_r <= S_PER_W;
        S_PER_W: begin
          if (mdu_done) begin
            acc_r   <= mdu_result;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // hold here until the result register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            cmp_r       <= cmp_fin;
            off_r       <= (level_r <= OFF_LSB);
            lvl_out_r   <= level_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_compare_value = cmp_r;
  assign out_is_off        = off_r;
  assign out_level_out     = lvl_out_r;

`ifndef ASSERT_OFF
  // the shared unit only finishes work that the sequencer is waiting for
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_done |-> (state_r != S_IDLE))
    else $error("multiply/divide completion while sequencer idle");

  // level stays within 0..1.0
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= FULL_LEVEL)
    else $error("level above full scale");

  // a new result only ever comes from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

  // an accepted transaction closes the input until its result is out
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input open right after accepting a transaction");
`endif

endmodule
